[hw/rtl/ssm_pkg.sv]
// Shared types for the sorted sequence merge block.
// Request and result payloads, op codes, and the controller/datapath link.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ssm_pkg;

  localparam int unsigned ValueWidth = 32;

  typedef enum logic [1:0] {
    OP_APPEND_FIRST  = 2'd0,
    OP_APPEND_SECOND = 2'd1,
    OP_MERGE         = 2'd2,
    OP_NONE          = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]                   op;
    logic signed [ValueWidth-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [ValueWidth-1:0] merged_value;
    logic                         from_second;
    logic                         last;
  } out_t;

  // Controller to datapath.
  typedef struct packed {
    logic wr_first;
    logic wr_second;
    logic step;
    logic clear;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic both_empty;
    logic at_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[hw/rtl/sorted_sequence_merge_core.sv]
// Top level of the sorted sequence merge block.
// Depends on ssm_pkg, ssm_ctrl, ssm_datapath and ssm_ram.
//
// Appends (op 0 to the first, op 1 to the second sequence) are taken one per
// cycle while the input is not stalled; an append to a full sequence of
// DEPTH entries is dropped. A merge request (op 2) emits all stored elements
// as one run, ascending when both sequences are sorted, one result per cycle
// while the output is not stalled, with ties going to the second sequence and
// the final result marked by last; both sequences are then empty. The input
// stalls from the cycle after a merge request until the last result has
// entered the output register. The result rate is set by the single read
// port of each sequence store, which yields one head element per cycle. A
// merge of two empty sequences emits nothing. Op 3 is ignored.
`timescale 1ns / 1ps
`default_nettype none

module sorted_sequence_merge_core #(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire ssm_pkg::in_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output ssm_pkg::out_t     out_data_o
);
  import ssm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ssm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (in_data_i.op),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ssm_datapath #(.DEPTH(DEPTH)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .value_i     (in_data_i.value),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // A result is only produced when the output register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> (!out_valid_o || !out_stall_i))
    else $error("merge step while output register is occupied");

  // While a merge runs, at least one sequence still holds elements.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> !sts.both_empty)
    else $error("merge running with both sequences empty");

  // The last element of a run releases the input and empties both stores.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.step && sts.at_last) |=> (!in_stall_o && sts.both_empty &&
                                   out_valid_o && out_data_o.last))
    else $error("merge run did not finish cleanly");

  // Appends are never taken while a merge runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.wr_first || cmd.wr_second) |-> !cmd.step)
    else $error("append overlapping a merge step");

endmodule

`default_nettype wire

[hw/rtl/ssm_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ssm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                   wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                   rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[hw/rtl/ssm_datapath.sv]
// Datapath of the sorted sequence merge: two sequence stores, fill counts,
// read pointers, head compare and the result register. Uses ssm_pkg, ssm_ram.
`timescale 1ns / 1ps
`default_nettype none

module ssm_datapath #(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire ssm_pkg::cmd_t                       cmd_i,
  input  wire logic signed [ssm_pkg::ValueWidth-1:0] value_i,
  output ssm_pkg::sts_t                            sts_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output ssm_pkg::out_t                            out_data_o
);
  import ssm_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0] cnt1_q, cnt1_d, cnt2_q, cnt2_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d;
  logic [AW-1:0] raddr1, raddr2;
  logic [ValueWidth-1:0] head1, head2;
  logic          take_first;
  logic [CW:0]   total, pos_next;
  logic          wr1, wr2;
  logic          out_valid_q, out_valid_d;
  out_t          out_q, out_d;

  assign wr1 = cmd_i.wr_first  && (cnt1_q < CW'(DEPTH));
  assign wr2 = cmd_i.wr_second && (cnt2_q < CW'(DEPTH));

  // The read address follows the next pointer (zero once it reaches DEPTH), so
  // the registered read data is the current head of each sequence.
  assign raddr1 = (i_d < CW'(DEPTH)) ? i_d[AW-1:0] : '0;
  assign raddr2 = (j_d < CW'(DEPTH)) ? j_d[AW-1:0] : '0;

  ssm_ram #(.WIDTH(ValueWidth), .DEPTH(DEPTH)) u_ram_first (
    .clk_i   (clk_i),
    .we_i    (wr1),
    .waddr_i (cnt1_q[AW-1:0]),
    .wdata_i (value_i),
    .raddr_i (raddr1),
    .rdata_o (head1)
  );

  ssm_ram #(.WIDTH(ValueWidth), .DEPTH(DEPTH)) u_ram_second (
    .clk_i   (clk_i),
    .we_i    (wr2),
    .waddr_i (cnt2_q[AW-1:0]),
    .wdata_i (value_i),
    .raddr_i (raddr2),
    .rdata_o (head2)
  );

  // Ties go to the second sequence.
  assign take_first = (i_q < cnt1_q) &&
                      ((j_q >= cnt2_q) || ($signed(head1) < $signed(head2)));
  assign total    = {1'b0, cnt1_q} + {1'b0, cnt2_q};
  assign pos_next = {1'b0, i_q} + {1'b0, j_q} + (CW+1)'(1);

  assign sts_o.both_empty = (cnt1_q == '0) && (cnt2_q == '0);
  assign sts_o.at_last    = (pos_next == total);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    cnt1_d      = cnt1_q;
    cnt2_d      = cnt2_q;
    i_d         = i_q;
    j_d         = j_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (wr1) begin
      cnt1_d = cnt1_q + CW'(1);
    end
    if (wr2) begin
      cnt2_d = cnt2_q + CW'(1);
    end
    if (cmd_i.step) begin
      out_valid_d        = 1'b1;
      out_d.merged_value = take_first ? head1 : head2;
      out_d.from_second  = !take_first;
      out_d.last         = sts_o.at_last;
      if (take_first) begin
        i_d = i_q + CW'(1);
      end else begin
        j_d = j_q + CW'(1);
      end
    end
    if (cmd_i.clear) begin
      cnt1_d = '0;
      cnt2_d = '0;
      i_d    = '0;
      j_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt1_q      <= '0;
      cnt2_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt1_q      <= cnt1_d;
      cnt2_q      <= cnt2_d;
      i_q         <= i_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[hw/rtl/ssm_ctrl.sv]
// Controller of the sorted sequence merge: decodes requests and sequences
// the merge run. Uses ssm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssm_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [1:0]    op_i,
  output logic               in_stall_o,
  input  wire ssm_pkg::sts_t sts_i,
  output ssm_pkg::cmd_t      cmd_o
);
  import ssm_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_e;

  state_e state_q, state_d;
  logic   stall_q, stall_d;
  logic   accept;

  assign accept = in_valid_i && !stall_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_e'(op_i))
            OP_APPEND_FIRST:  cmd_o.wr_first  = 1'b1;
            OP_APPEND_SECOND: cmd_o.wr_second = 1'b1;
            OP_MERGE: begin
              // A merge of two empty sequences emits nothing.
              if (!sts_i.both_empty) begin
                state_d = ST_MERGE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MERGE: begin
        if (sts_i.out_free) begin
          cmd_o.step = 1'b1;
          if (sts_i.at_last) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    stall_d = (state_d != ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= stall_d;
    end
  end

  assign in_stall_o = stall_q;

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for sorted_sequence_merge_core: append and merge requests
// are driven with random gaps, and every merged result is checked against a predictor.
// Depends on ssm_pkg and the sorted_sequence_merge_core RTL.
`timescale 1ns / 1ps

module testbench;
  import ssm_pkg::*;

  localparam int DEPTH = 32;
  localparam int QUIET_LIMIT = 500;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_REQUESTS = 140;

  typedef struct {
    in_t req;
    bit  hold;  // wait until every merged result has arrived before presenting
  } stim_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  stim_t request_q[$];
  out_t merged_q[$];

  logic signed [31:0] first_seq[DEPTH];
  logic signed [31:0] second_seq[DEPTH];
  int unsigned first_len = 0;
  int unsigned second_len = 0;

  int results_due = 0;
  int results_done = 0;
  int error_count = 0;
  int quiet_cycles = 0;
  bit hold_next = 1'b0;

  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int stall_left = 0;

  sorted_sequence_merge_core #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  // Applies one accepted request to the tracked sequences and queues the
  // merged run that a merge request produces.
  task automatic track_request(input in_t req);
    int unsigned i;
    int unsigned j;
    int unsigned total;
    out_t res;
    i = 0;
    j = 0;
    case (op_e'(req.op))
      OP_APPEND_FIRST: begin
        if (first_len < DEPTH) begin
          first_seq[first_len] = req.value;
          first_len++;
        end
      end
      OP_APPEND_SECOND: begin
        if (second_len < DEPTH) begin
          second_seq[second_len] = req.value;
          second_len++;
        end
      end
      OP_MERGE: begin
        total = first_len + second_len;
        for (int k = 0; k < total; k++) begin
          // The first sequence wins only when strictly smaller.
          if (i < first_len && (j >= second_len || first_seq[i] < second_seq[j])) begin
            res.merged_value = first_seq[i];
            res.from_second = 1'b0;
            i++;
          end else begin
            res.merged_value = second_seq[j];
            res.from_second = 1'b1;
            j++;
          end
          res.last = (k + 1 == total);
          merged_q.push_back(res);
          results_due++;
        end
        first_len = 0;
        second_len = 0;
      end
      default: ;
    endcase
  endtask

  task automatic add_request(input op_e op, input logic signed [31:0] value);
    stim_t s;
    s.req.op = op;
    s.req.value = value;
    s.hold = hold_next;
    hold_next = 1'b0;
    request_q.push_back(s);
  endtask

  function automatic int draw_value(input bit narrow);
    if (narrow) return $urandom_range(0, 8) - 4;
    return int'($urandom);
  endfunction

  // One merge request preceded by appends in random interleaving, with occasional ignored op codes.
  task automatic add_merge_group(output int count);
    int n1;
    int n2;
    int kind;
    bit narrow;
    bit sorted;
    int a[$];
    int b[$];
    kind = $urandom_range(0, 9);
    n1 = (kind == 0 || kind == 2) ? $urandom_range(30, 36) : $urandom_range(0, 6);
    n2 = (kind == 1 || kind == 2) ? $urandom_range(30, 36) : $urandom_range(0, 6);
    narrow = ($urandom_range(0, 2) == 0);
    sorted = ($urandom_range(0, 6) != 0);
    for (int k = 0; k < n1; k++) a.push_back(draw_value(narrow));
    for (int k = 0; k < n2; k++) b.push_back(draw_value(narrow));
    if (sorted) begin
      a.sort();
      b.sort();
    end
    hold_next = ($urandom_range(0, 5) == 0);
    while (a.size() != 0 || b.size() != 0) begin
      if ($urandom_range(0, 15) == 0) add_request(OP_NONE, int'($urandom));
      if (b.size() == 0 || (a.size() != 0 && $urandom_range(0, 1) == 0))
        add_request(OP_APPEND_FIRST, a.pop_front());
      else
        add_request(OP_APPEND_SECOND, b.pop_front());
    end
    add_request(OP_MERGE, int'($urandom));
    count = n1 + n2 + 1;
  endtask

  // Driver: holds a stalled request steady, otherwise presents the next one
  // in bursts separated by random gaps.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && in_stall_o) begin
      in_valid_i <= 1'b1;
    end else begin
      if (in_valid_i) begin
        track_request(in_data_i);
        void'(request_q.pop_front());
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (request_q.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (request_q[0].hold && results_due != results_done) begin
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        in_data_i <= request_q[0].req;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest expectation and
  // drives the output stall in phases of free flow, random and long stalls.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_done <= results_done + 1;
        if (merged_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result value %0d", out_data_o.merged_value));
        end else begin
          want = merged_q.pop_front();
          if (out_data_o.merged_value !== want.merged_value)
            report_mismatch($sformatf("merged_value got %0d want %0d",
                                      out_data_o.merged_value, want.merged_value));
          if (out_data_o.from_second !== want.from_second)
            report_mismatch($sformatf("from_second got %b want %b for value %0d",
                                      out_data_o.from_second, want.from_second,
                                      want.merged_value));
          if (out_data_o.last !== want.last)
            report_mismatch($sformatf("last got %b want %b for value %0d",
                                      out_data_o.last, want.last, want.merged_value));
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 2) == 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            out_stall_i <= 1'b1;
          end else begin
            out_stall_i <= 1'b0;
            stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
          end
        end
      endcase
    end
  end

  // Watchdog on cycles in which neither channel moves anything.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int added;
    int count;
    // Merge of two empty sequences, then an unused op code.
    add_request(OP_MERGE, 32'sh7FFF_FFFF);
    add_request(OP_NONE, 32'sh5A5A_A5A5);
    // Extremes on both sides with ties at the minimum, zero and the maximum.
    add_request(OP_APPEND_FIRST, 32'sh8000_0000);
    add_request(OP_APPEND_SECOND, 32'sh8000_0000);
    add_request(OP_APPEND_FIRST, -32'sd1);
    add_request(OP_APPEND_SECOND, 32'sd0);
    add_request(OP_APPEND_FIRST, 32'sd0);
    add_request(OP_APPEND_SECOND, 32'sd5);
    add_request(OP_APPEND_FIRST, 32'sh7FFF_FFFF);
    add_request(OP_APPEND_SECOND, 32'sh7FFF_FFFF);
    add_request(OP_MERGE, -32'sd1);
    // Only the first sequence, given out of order.
    hold_next = 1'b1;
    add_request(OP_APPEND_FIRST, 32'sd7);
    add_request(OP_APPEND_FIRST, 32'sd3);
    add_request(OP_APPEND_FIRST, 32'sd9);
    add_request(OP_MERGE, 32'sd0);
    // Only the second sequence.
    add_request(OP_APPEND_SECOND, 32'sd12);
    add_request(OP_MERGE, 32'sh8000_0000);
    // An ignored op code between appends must not disturb the stores.
    add_request(OP_APPEND_FIRST, 32'sd1);
    add_request(OP_NONE, -32'sd1);
    add_request(OP_APPEND_SECOND, 32'sd1);
    add_request(OP_MERGE, 32'sh5555_5555);

    added = 0;
    while (added < RANDOM_REQUESTS) begin
      add_merge_group(count);
      added += count;
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || in_valid_i || results_done != results_due)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (merged_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", merged_q.size()));

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/ssm_pkg.sv
hw/rtl/ssm_ram.sv
hw/rtl/ssm_datapath.sv
hw/rtl/ssm_ctrl.sv
hw/rtl/sorted_sequence_merge_core.sv
tb/sv/testbench.sv
